### src/gek_pkg.sv
// Package for the gamepad event to key translator.
// Holds the queue entry type, event and key code constants, and the button key tables.
// No dependencies.
package gek_pkg;

    localparam int unsigned CfgRegs = 8;

    typedef logic [CfgRegs-1:0][31:0] t_cfg_regs;

    localparam logic [15:0] EvTypeKey = 16'd1;
    localparam logic [15:0] EvTypeAbs = 16'd3;

    localparam logic [15:0] BtnBaseA = 16'h0120;
    localparam logic [15:0] BtnBaseB = 16'h0130;
    localparam logic [15:0] BtnEnd   = 16'h0140;

    localparam logic [15:0] AbsX    = 16'd0;
    localparam logic [15:0] AbsY    = 16'd1;
    localparam logic [15:0] AbsHatX = 16'd16;
    localparam logic [15:0] AbsHatY = 16'd17;

    localparam logic [9:0] KeyLeft  = 10'd105;
    localparam logic [9:0] KeyRight = 10'd106;
    localparam logic [9:0] KeyUp    = 10'd103;
    localparam logic [9:0] KeyDown  = 10'd108;

    localparam logic OutTypeSync = 1'b0;
    localparam logic OutTypeKey  = 1'b1;

    // One classified transaction waiting for the back end.
    typedef struct packed {
        logic        is_axis;
        logic        vert;
        logic        neg_on;
        logic        pos_on;
        logic [9:0]  code;
        logic [31:0] value;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [9:0] key_range_a(input logic [3:0] idx);
        logic [9:0] k;
        case (idx)
            4'd0:    k = 10'd28;
            4'd1:    k = 10'd57;
            4'd2:    k = 10'd44;
            4'd3:    k = 10'd45;
            4'd4:    k = 10'd30;
            4'd5:    k = 10'd31;
            4'd6:    k = 10'd16;
            4'd7:    k = 10'd17;
            4'd8:    k = 10'd15;
            4'd9:    k = 10'd1;
            4'd10:   k = 10'd42;
            4'd11:   k = 10'd29;
            4'd12:   k = 10'd2;
            4'd13:   k = 10'd3;
            4'd14:   k = 10'd4;
            4'd15:   k = 10'd5;
            default: k = 10'd0;
        endcase
        return k;
    endfunction

    function automatic logic [9:0] key_range_b(input logic [3:0] idx);
        logic [9:0] k;
        case (idx)
            4'd0:    k = 10'd45;
            4'd1:    k = 10'd28;
            4'd2:    k = 10'd1;
            4'd3:    k = 10'd57;
            4'd4:    k = 10'd30;
            4'd5:    k = 10'd31;
            4'd6:    k = 10'd16;
            4'd7:    k = 10'd17;
            4'd8:    k = 10'd15;
            4'd9:    k = 10'd28;
            4'd10:   k = 10'd42;
            4'd11:   k = 10'd29;
            4'd12:   k = 10'd1;
            4'd13:   k = 10'd14;
            4'd14:   k = 10'd6;
            4'd15:   k = 10'd7;
            default: k = 10'd0;
        endcase
        return k;
    endfunction

endpackage

### src/gamepad_event_to_key_translator.sv
// Top level of the gamepad event to key translator.
// Instantiates gek_cfg, gek_front, gek_queue and gek_back; uses gek_pkg.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_event_type, i_event_code, i_event_value
//   out      output     o_out_valid / i_out_stall o_out_type, o_out_code, o_out_value, o_last
//   config   input      psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// The front end takes one transaction per cycle unless the queue is full, and spends one
// registered stage on the range arithmetic before pushing into the queue. The back end emits
// one report per cycle; a stalled output holds its report while the queue still fills. A
// button transaction gives a key and a sync report, an axis transaction one such pair per
// arrow that it changes. Reset clears the arrow states, the ranges and the queue.
module gamepad_event_to_key_translator #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_event_type,
    input  logic [15:0]        i_event_code,
    input  logic signed [31:0] i_event_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_out_type,
    output logic [9:0]         o_out_code,
    output logic signed [31:0] o_out_value,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gek_pkg::*;

    t_cfg_regs cfg;
    t_entry    push_entry;
    t_entry    head;
    t_q_status q_status;
    logic      push;
    logic      pop;
    logic [31:0] out_value;

    assign pready = 1'b1;

    gek_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    gek_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_event_type  (i_event_type),
        .i_event_code  (i_event_code),
        .i_event_value (i_event_value),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    gek_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    gek_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_type  (o_out_type),
        .o_out_code  (o_out_code),
        .o_out_value (out_value),
        .o_last      (o_last)
    );

    assign o_out_value = out_value;

endmodule

### src/gek_cfg.sv
// APB-style register file holding the four axis ranges.
// Depends on gek_pkg.
module gek_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output gek_pkg::t_cfg_regs o_cfg
);
    import gek_pkg::*;

    t_cfg_regs r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            r_cfg[paddr[4:2]] <= pwdata;
        end
    end

    assign prdata = r_cfg[paddr[4:2]];
    assign o_cfg  = r_cfg;

endmodule

### src/gek_front.sv
// Front end: accepts input transactions, looks up button keys, and for axis events
// computes the midpoint and dead zone, then the two direction flags. Depends on gek_pkg.
module gek_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gek_pkg::t_cfg_regs i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_event_type,
    input  logic [15:0]        i_event_code,
    input  logic signed [31:0] i_event_value,
    input  gek_pkg::t_q_status i_q_status,
    output logic               o_push,
    output gek_pkg::t_entry    o_entry
);
    import gek_pkg::*;

    logic               r_valid;
    logic               r_keep;
    logic               r_is_axis;
    logic               r_vert;
    logic [9:0]         r_code;
    logic signed [31:0] r_value;
    logic signed [31:0] r_mid;
    logic [30:0]        r_dead;

    logic               n_keep;
    logic               n_is_axis;
    logic               n_vert;
    logic [9:0]         n_code;
    logic [1:0]         pair;
    logic signed [32:0] lo;
    logic signed [32:0] hi;
    logic signed [32:0] sum;
    logic signed [32:0] sum_adj;
    logic signed [32:0] diff;
    logic [30:0]        dead_raw;
    logic [30:0]        n_dead;
    logic               take;
    logic signed [33:0] v_plus;
    logic signed [33:0] v_minus;
    logic signed [33:0] mid_ext;

    // Classification of the incoming transaction.
    always_comb begin
        n_keep    = 1'b0;
        n_is_axis = 1'b0;
        n_vert    = 1'b0;
        n_code    = '0;
        pair      = 2'd0;
        if (i_event_type == EvTypeKey) begin
            if (i_event_code inside {[BtnBaseA:BtnEnd-16'd1]}) begin
                n_keep = 1'b1;
                n_code = i_event_code[4] ? key_range_b(i_event_code[3:0])
                                         : key_range_a(i_event_code[3:0]);
            end
        end else if (i_event_type == EvTypeAbs) begin
            case (i_event_code)
                AbsX: begin
                    n_keep = 1'b1; n_is_axis = 1'b1; n_vert = 1'b0; pair = 2'd0;
                end
                AbsY: begin
                    n_keep = 1'b1; n_is_axis = 1'b1; n_vert = 1'b1; pair = 2'd1;
                end
                AbsHatX: begin
                    n_keep = 1'b1; n_is_axis = 1'b1; n_vert = 1'b0; pair = 2'd2;
                end
                AbsHatY: begin
                    n_keep = 1'b1; n_is_axis = 1'b1; n_vert = 1'b1; pair = 2'd3;
                end
                default: begin
                    n_keep = 1'b0;
                end
            endcase
        end
    end

    // Midpoint rounds toward zero: a negative sum gets one added before the shift.
    always_comb begin
        lo       = {i_cfg[{pair, 1'b0}][31], i_cfg[{pair, 1'b0}]};
        hi       = {i_cfg[{pair, 1'b1}][31], i_cfg[{pair, 1'b1}]};
        sum      = lo + hi;
        sum_adj  = sum + {32'd0, sum[32]};
        diff     = hi - lo;
        dead_raw = diff[32:2];
        n_dead   = (dead_raw == '0) ? 31'd1 : dead_raw;
    end

    // An axis whose range is empty produces nothing and is dropped here.
    assign take       = !r_valid || !r_keep || !i_q_status.full;
    assign o_in_stall = !take;
    assign o_push     = r_valid && r_keep && !i_q_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in_valid) begin
            r_keep    <= n_keep && (!n_is_axis || (hi > lo));
            r_is_axis <= n_is_axis;
            r_vert    <= n_vert;
            r_code    <= n_code;
            r_value   <= i_event_value;
            r_mid     <= sum_adj[32:1];
            r_dead    <= n_dead;
        end
    end

    // v < mid - dead is tested as v + dead < mid, and v > mid + dead as v - dead > mid.
    always_comb begin
        mid_ext        = {{2{r_mid[31]}}, r_mid};
        v_plus         = {{2{r_value[31]}}, r_value} + {3'd0, r_dead};
        v_minus        = {{2{r_value[31]}}, r_value} - {3'd0, r_dead};
        o_entry.is_axis = r_is_axis;
        o_entry.vert    = r_vert;
        o_entry.neg_on  = v_plus < mid_ext;
        o_entry.pos_on  = v_minus > mid_ext;
        o_entry.code    = r_code;
        o_entry.value   = r_value;
    end

endmodule

### src/gek_queue.sv
// Small FIFO of classified transactions between the front and back ends.
// Depends on gek_pkg.
module gek_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gek_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output gek_pkg::t_entry    o_head,
    output gek_pkg::t_q_status o_status
);
    import gek_pkg::*;

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_entry          r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FullCnt);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### src/gek_back.sv
// Back end: holds the four arrow states and serializes key and sync reports
// from the queue head into the output register. Depends on gek_pkg.
module gek_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gek_pkg::t_entry    i_head,
    input  gek_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_out_type,
    output logic [9:0]         o_out_code,
    output logic [31:0]        o_out_value,
    output logic               o_last
);
    import gek_pkg::*;

    typedef enum logic [3:0] {
        PH_NEG_KEY  = 4'b0001,
        PH_NEG_SYNC = 4'b0010,
        PH_POS_KEY  = 4'b0100,
        PH_POS_SYNC = 4'b1000
    } t_phase;

    t_phase      r_ph;
    t_phase      n_ph;
    t_phase      ph_eff;
    logic [3:0]  r_held;
    logic [3:0]  n_held;
    logic        r_out_valid;
    logic        r_out_type;
    logic [9:0]  r_out_code;
    logic [31:0] r_out_value;
    logic        r_last;

    logic        out_free;
    logic        h_valid;
    logic [1:0]  neg_bit;
    logic [1:0]  pos_bit;
    logic        neg_chg;
    logic        pos_chg;
    logic        skip;
    logic        is_final;
    logic        emit;
    logic        e_type;
    logic [9:0]  e_code;
    logic [31:0] e_value;

    function automatic logic [9:0] arrow_key(input logic [1:0] idx);
        logic [9:0] k;
        case (idx)
            2'd0:    k = KeyLeft;
            2'd1:    k = KeyRight;
            2'd2:    k = KeyUp;
            2'd3:    k = KeyDown;
            default: k = KeyLeft;
        endcase
        return k;
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign h_valid  = !i_q_status.empty;
    assign neg_bit  = {i_head.vert, 1'b0};
    assign pos_bit  = {i_head.vert, 1'b1};
    assign neg_chg  = i_head.neg_on != r_held[neg_bit];
    assign pos_chg  = i_head.pos_on != r_held[pos_bit];

    always_comb begin
        ph_eff = r_ph;
        if (i_head.is_axis && r_ph == PH_NEG_KEY && !neg_chg) begin
            ph_eff = PH_POS_KEY;
        end
        // An axis transaction that changes no arrow is dropped without a report.
        skip = h_valid && i_head.is_axis && r_ph == PH_NEG_KEY && !neg_chg && !pos_chg;

        n_held   = r_held;
        is_final = 1'b0;
        e_type   = OutTypeSync;
        e_code   = '0;
        e_value  = '0;
        case (ph_eff)
            PH_NEG_KEY: begin
                e_type = OutTypeKey;
                if (i_head.is_axis) begin
                    e_code          = arrow_key(neg_bit);
                    e_value         = {31'd0, i_head.neg_on};
                    n_held[neg_bit] = i_head.neg_on;
                end else begin
                    e_code  = i_head.code;
                    e_value = i_head.value;
                end
            end
            PH_NEG_SYNC: begin
                is_final = !i_head.is_axis || !pos_chg;
            end
            PH_POS_KEY: begin
                e_type          = OutTypeKey;
                e_code          = arrow_key(pos_bit);
                e_value         = {31'd0, i_head.pos_on};
                n_held[pos_bit] = i_head.pos_on;
            end
            PH_POS_SYNC: begin
                is_final = 1'b1;
            end
            default: begin
                is_final = 1'b1;
            end
        endcase

        emit  = h_valid && out_free && !skip;
        o_pop = skip || (emit && is_final);

        if (o_pop) begin
            n_ph = PH_NEG_KEY;
        end else if (emit) begin
            case (ph_eff)
                PH_NEG_KEY:  n_ph = PH_NEG_SYNC;
                PH_NEG_SYNC: n_ph = PH_POS_KEY;
                PH_POS_KEY:  n_ph = PH_POS_SYNC;
                default:     n_ph = PH_NEG_KEY;
            endcase
        end else begin
            n_ph = r_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= PH_NEG_KEY;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ph <= n_ph;
            if (emit) begin
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_type  <= e_type;
            r_out_code  <= e_code;
            r_out_value <= e_value;
            r_last      <= is_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_type  = r_out_type;
    assign o_out_code  = r_out_code;
    assign o_out_value = r_out_value;
    assign o_last      = r_last;

endmodule

### test/gamepad_event_to_key_translator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for gamepad_event_to_key_translator: drives gamepad events,
// predicts the key and sync reports and checks every output transaction in order.
// Depends on gek_pkg and the gamepad_event_to_key_translator top level.
module gamepad_event_to_key_translator_test;
    import gek_pkg::*;

    localparam int RegXLow     = 0;
    localparam int RegYLow     = 2;
    localparam int RegHatXLow  = 4;
    localparam int RegHatYLow  = 6;

    localparam int ArrowLeft  = 0;
    localparam int ArrowRight = 1;
    localparam int ArrowUp    = 2;
    localparam int ArrowDown  = 3;

    localparam int SettleCycles = 16;

    typedef struct packed {
        logic [15:0] ev_type;
        logic [15:0] ev_code;
        logic [31:0] ev_value;
    } pad_event_t;

    typedef struct packed {
        logic        kind;
        logic [9:0]  code;
        logic [31:0] value;
        logic        last;
    } key_report_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [15:0]        i_event_type = '0;
    logic [15:0]        i_event_code = '0;
    logic signed [31:0] i_event_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_out_type;
    logic [9:0]         o_out_code;
    logic signed [31:0] o_out_value;
    logic               o_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    gamepad_event_to_key_translator dut (.*);

    always #4 i_clk = ~i_clk;

    // Key codes for button codes 0x120 through 0x13F, in order.
    logic [9:0] button_keys [32] = '{
        28, 57, 44, 45, 30, 31, 16, 17, 15, 1, 42, 29, 2, 3, 4, 5,
        45, 28, 1, 57, 30, 31, 16, 17, 15, 28, 42, 29, 1, 14, 6, 7
    };

    logic signed [31:0] range_regs [8];
    logic [3:0]         arrows_held = 4'b0;
    key_report_t        expected_reports [$];
    pad_event_t         pending_events [$];
    key_report_t        staged;
    bit                 staged_ok;
    pad_event_t         next_event;
    key_report_t        want;
    int                 events_taken = 0;
    int                 reports_seen = 0;
    int                 mismatches = 0;
    int                 sender_gap_pct;
    int                 receiver_stall_pct;

    always_comb begin
        if (events_taken < 156) begin
            sender_gap_pct = 32;
            receiver_stall_pct = 82;
        end else if (events_taken < 312) begin
            sender_gap_pct = 82;
            receiver_stall_pct = 32;
        end else begin
            sender_gap_pct = 0;
            receiver_stall_pct = 0;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Each report is held back one step so the final one of an event can be flagged.
    function automatic void stage_report(input logic kind, input logic [9:0] code,
                                         input logic [31:0] value);
        if (staged_ok)
            expected_reports.push_back(staged);
        staged = {kind, code, value, 1'b0};
        staged_ok = 1'b1;
    endfunction

    function automatic void stage_key_pair(input logic [9:0] code, input logic [31:0] value);
        stage_report(OutTypeKey, code, value);
        stage_report(OutTypeSync, 10'd0, 32'd0);
    endfunction

    function automatic void set_arrow(input int idx, input bit on);
        logic [9:0] key;
        case (idx)
            ArrowLeft:  key = KeyLeft;
            ArrowRight: key = KeyRight;
            ArrowUp:    key = KeyUp;
            default:    key = KeyDown;
        endcase
        if (arrows_held[idx] != on) begin
            arrows_held[idx] = on;
            stage_key_pair(key, {31'd0, on});
        end
    endfunction

    // Range math in 64 bits; SystemVerilog division truncates toward zero.
    function automatic void steer_axis(input int low_reg, input int neg_arrow,
                                       input longint pos);
        longint lo, hi, mid, dead;
        lo = range_regs[low_reg];
        hi = range_regs[low_reg + 1];
        if (hi > lo) begin
            mid = (lo + hi) / 2;
            dead = (hi - lo) / 4;
            if (dead < 1)
                dead = 1;
            set_arrow(neg_arrow, pos < mid - dead);
            set_arrow(neg_arrow + 1, pos > mid + dead);
        end
    endfunction

    function automatic void translate_event(input logic [15:0] ev_type,
                                            input logic [15:0] ev_code,
                                            input logic signed [31:0] ev_value);
        staged_ok = 1'b0;
        if (ev_type == EvTypeKey) begin
            if (ev_code >= BtnBaseA && ev_code < BtnEnd)
                stage_key_pair(button_keys[ev_code - BtnBaseA], ev_value);
        end else if (ev_type == EvTypeAbs) begin
            case (ev_code)
                AbsX:    steer_axis(RegXLow, ArrowLeft, ev_value);
                AbsY:    steer_axis(RegYLow, ArrowUp, ev_value);
                AbsHatX: steer_axis(RegHatXLow, ArrowLeft, ev_value);
                AbsHatY: steer_axis(RegHatYLow, ArrowUp, ev_value);
                default: ;
            endcase
        end
        if (staged_ok) begin
            staged.last = 1'b1;
            expected_reports.push_back(staged);
        end
    endfunction

    // Mostly buttons and axis positions close to the dead zone edges, some noise.
    function automatic pad_event_t random_event();
        pad_event_t ev;
        int axis;
        longint lo, hi, mid, dead, v;
        ev.ev_value = $urandom;
        case ($urandom_range(9))
            0, 1, 2: begin
                ev.ev_type = EvTypeKey;
                ev.ev_code = BtnBaseA + 16'($urandom_range(31));
                if ($urandom_range(1))
                    ev.ev_value = $urandom_range(2);
            end
            3, 4, 5, 6, 7: begin
                axis = $urandom_range(3);
                ev.ev_type = EvTypeAbs;
                case (axis)
                    0:       ev.ev_code = AbsX;
                    1:       ev.ev_code = AbsY;
                    2:       ev.ev_code = AbsHatX;
                    default: ev.ev_code = AbsHatY;
                endcase
                lo = range_regs[2 * axis];
                hi = range_regs[2 * axis + 1];
                if (hi > lo) begin
                    mid = (lo + hi) / 2;
                    dead = (hi - lo) / 4;
                    if (dead < 1)
                        dead = 1;
                    case ($urandom_range(6))
                        0, 1:    v = mid - dead + longint'($urandom_range(4)) - 2;
                        2, 3:    v = mid + dead + longint'($urandom_range(4)) - 2;
                        4:       v = mid;
                        5:       v = $urandom_range(1) ? lo : hi;
                        default: v = lo + (longint'($urandom) % (hi - lo + 1));
                    endcase
                    ev.ev_value = v[31:0];
                end
            end
            default: begin
                case ($urandom_range(2))
                    0:       ev.ev_type = EvTypeKey;
                    1:       ev.ev_type = EvTypeAbs;
                    default: ev.ev_type = 16'($urandom);
                endcase
                ev.ev_code = 16'($urandom);
            end
        endcase
        return ev;
    endfunction

    task automatic write_range_reg(input int index, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(index * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        range_regs[index] = value;
    endtask

    task automatic load_ranges(input logic [31:0] xl, xh, yl, yh, hxl, hxh, hyl, hyh);
        write_range_reg(RegXLow, xl);
        write_range_reg(RegXLow + 1, xh);
        write_range_reg(RegYLow, yl);
        write_range_reg(RegYLow + 1, yh);
        write_range_reg(RegHatXLow, hxl);
        write_range_reg(RegHatXLow + 1, hxh);
        write_range_reg(RegHatYLow, hyl);
        write_range_reg(RegHatYLow + 1, hyh);
    endtask

    task automatic random_ranges();
        logic [31:0] bounds [8];
        logic [31:0] tmp;
        for (int r = 0; r < 8; r += 2) begin
            bounds[r] = $urandom;
            case ($urandom_range(3))
                0:       bounds[r + 1] = $urandom;
                1:       bounds[r + 1] = bounds[r] + $urandom_range(1, 9);
                2:       bounds[r + 1] = bounds[r] + $urandom_range(1, 1 << 20);
                default: bounds[r + 1] = bounds[r] + $urandom;
            endcase
            // Leave an occasional inverted range so an axis now and then stays unused.
            if ($signed(bounds[r + 1]) <= $signed(bounds[r]) && $urandom_range(3) != 0) begin
                tmp = bounds[r];
                bounds[r] = bounds[r + 1];
                bounds[r + 1] = tmp;
            end
        end
        load_ranges(bounds[0], bounds[1], bounds[2], bounds[3],
                    bounds[4], bounds[5], bounds[6], bounds[7]);
    endtask

    task automatic queue_event(input logic [15:0] ev_type, input logic [15:0] ev_code,
                               input logic [31:0] ev_value);
        pending_events.push_back({ev_type, ev_code, ev_value});
    endtask

    task automatic queue_random(input int count);
        repeat (count) pending_events.push_back(random_event());
    endtask

    // Wait until every event is taken and every report is back, then let the
    // pipeline empty out events that produce nothing.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_events.size() != 0 || i_in_valid || expected_reports.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                translate_event(i_event_type, i_event_code, i_event_value);
                events_taken <= events_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                    next_event = pending_events.pop_front();
                    i_event_type <= next_event.ev_type;
                    i_event_code <= next_event.ev_code;
                    i_event_value <= next_event.ev_value;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                reports_seen++;
                if (expected_reports.size() == 0) begin
                    report_mismatch($sformatf("unexpected report type %0d code %0d value %0d",
                                              o_out_type, o_out_code, o_out_value));
                end else begin
                    want = expected_reports.pop_front();
                    if (o_out_type !== want.kind)
                        report_mismatch($sformatf("type %0d, wanted %0d", o_out_type, want.kind));
                    if (o_out_code !== want.code)
                        report_mismatch($sformatf("code %0d, wanted %0d", o_out_code, want.code));
                    if (o_out_value !== want.value)
                        report_mismatch($sformatf("value %0d, wanted %0d",
                                                  o_out_value, $signed(want.value)));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0d, wanted %0d", o_last, want.last));
                end
            end
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    initial begin
        for (int r = 0; r < 8; r++)
            range_regs[r] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset every axis range is empty, so only buttons translate.
        queue_event(EvTypeKey, BtnBaseA, 32'd1);
        queue_event(EvTypeKey, BtnBaseA + 16'h000F, 32'd0);
        queue_event(EvTypeKey, BtnBaseB, 32'h7FFF_FFFF);
        queue_event(EvTypeKey, BtnEnd - 16'd1, 32'h8000_0000);
        queue_event(EvTypeKey, BtnBaseA - 16'd1, 32'd1);
        queue_event(EvTypeKey, BtnEnd, 32'd1);
        queue_event(16'd0, BtnBaseA, 32'd1);
        queue_event(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_event(EvTypeAbs, AbsX, 32'h8000_0000);
        queue_event(EvTypeAbs, 16'd2, 32'd0);
        drain();

        // Typical ranges; the hat Y range has an odd negative sum to probe rounding.
        load_ranges(32'd0, 32'd255, -32'sd32768, 32'sd32767, -32'sd1, 32'sd1, -32'sd7, 32'sd0);
        queue_event(EvTypeAbs, AbsX, 32'd0);
        queue_event(EvTypeAbs, AbsX, 32'd255);
        queue_event(EvTypeAbs, AbsX, 32'd127);
        queue_event(EvTypeAbs, AbsX, 32'd127);
        queue_event(EvTypeAbs, AbsY, -32'sd32768);
        queue_event(EvTypeAbs, AbsY, 32'sd32767);
        queue_event(EvTypeAbs, AbsHatX, -32'sd2);
        queue_event(EvTypeAbs, AbsHatX, 32'sd2);
        queue_event(EvTypeAbs, AbsHatY, -32'sd5);
        queue_event(EvTypeAbs, AbsHatY, -32'sd2);
        queue_event(EvTypeAbs, AbsHatY, -32'sd1);
        queue_random(110);
        drain();

        // Full-width X, the narrowest Y, an empty hat X and an inverted hat Y.
        load_ranges(32'h8000_0000, 32'h7FFF_FFFF, 32'd5, 32'd6,
                    32'd100, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_event(EvTypeAbs, AbsX, 32'h8000_0000);
        queue_event(EvTypeAbs, AbsX, 32'h7FFF_FFFF);
        queue_event(EvTypeAbs, AbsY, 32'd4);
        queue_event(EvTypeAbs, AbsY, 32'd3);
        queue_event(EvTypeAbs, AbsY, 32'd7);
        queue_event(EvTypeAbs, AbsHatX, 32'd0);
        queue_event(EvTypeAbs, AbsHatY, 32'd0);
        queue_random(110);
        drain();

        random_ranges();
        queue_random(110);
        drain();

        random_ranges();
        queue_random(110);
        drain();

        if (expected_reports.size() != 0)
            report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
        $display("Sent %0d gamepad events over five range settings, full-width and inverted",
                 events_taken);
        $display("ranges included; checked %0d key and sync reports.", reports_seen);
        if (mismatches == 0)
            $display("PASS gamepad_event_to_key_translator");
        else
            $display("FAIL gamepad_event_to_key_translator");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("FAIL gamepad_event_to_key_translator");
        $finish;
    end

endmodule
